@@ design/min_jerk_quintic_coeffs_unit_defines.svh @@
// Assertion macros for the minimum-jerk quintic coefficient unit.
`ifndef MIN_JERK_QUINTIC_COEFFS_UNIT_DEFINES_SVH
`define MIN_JERK_QUINTIC_COEFFS_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MJQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mjq: implication check failed");
`define MJQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mjq: next-cycle check failed");
`else
`define MJQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MJQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/mjq_pkg.sv @@
package mjq_pkg;

	localparam int ST_W = 32;
	localparam int T_W = 24;
	localparam int C_W = 48;
	localparam int Q_W = 48;
	// |numerator| of the upper coefficients stays below 2^85
	localparam int MAG_W = 85;
	localparam int N_W = 87;
	localparam int D3_W = 72;
	localparam int D4_W = 96;
	localparam int D5_W = 120;
	// numerator pre-shift: rounding bit plus Q8.16 scaling per power of T
	localparam int SH3 = 24;
	localparam int SH4 = 40;
	localparam int SH5 = 56;
	localparam int FE_STAGES = 7;
	localparam int DIV_LAT = Q_W + 3;

	localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

	typedef struct packed {
		logic signed [ST_W-1:0] start_position;
		logic signed [ST_W-1:0] start_velocity;
		logic signed [ST_W-1:0] start_accel;
		logic signed [ST_W-1:0] end_position;
		logic signed [ST_W-1:0] end_velocity;
		logic signed [ST_W-1:0] end_accel;
		logic [T_W-1:0] duration;
	} in_t;

	typedef struct packed {
		logic signed [C_W-1:0] coeff_0;
		logic signed [C_W-1:0] coeff_1;
		logic signed [C_W-1:0] coeff_2;
		logic signed [C_W-1:0] coeff_3;
		logic signed [C_W-1:0] coeff_4;
		logic signed [C_W-1:0] coeff_5;
		logic zero_duration;
		logic saturated;
	} out_t;

	// start state and zero flag riding alongside the arithmetic
	typedef struct packed {
		logic signed [ST_W-1:0] p0;
		logic signed [ST_W-1:0] v0;
		logic signed [ST_W-1:0] a0;
		logic zero;
	} side_t;

endpackage

@@ design/mjq_chan_if.sv @@
interface mjq_chan_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/min_jerk_quintic_coeffs_unit.sv @@
// Minimum-jerk quintic coefficient unit. Takes one beat per clock unless stalled and
// returns one result beat per input beat, in order. From an accepted input beat to
// the result beat on the output: 7 front-end stages build the powers of T
// (T^2..T^5, each from 24x24 partial products) and the numerators, then three
// parallel dividers of 51 stages each (set-up, range check, one quotient bit per
// stage for 48 bits, clamp and sign) produce coeff_3..coeff_5, then the output
// register. The output register lets a new beat enter while a result waits; the
// pipeline stalls only when the last stage holds a beat while a result waits.
`include "min_jerk_quintic_coeffs_unit_defines.svh"

module min_jerk_quintic_coeffs_unit (
	input  logic clk,
	input  logic arst_n,
	mjq_chan_if.sink   in_chan,
	mjq_chan_if.source out_chan
);
	localparam int PIPE_N = mjq_pkg::FE_STAGES + mjq_pkg::DIV_LAT;

	logic adv, v_fin, take;
	logic [PIPE_N-1:0] vld_s;
	logic out_valid_q;
	mjq_pkg::out_t out_q;
	mjq_pkg::in_t ib;
	mjq_pkg::side_t side_s [PIPE_N];

	// S1
	logic signed [32:0] dp_s1, dv_s1, d2_s1;
	logic [23:0] t_s1;
	logic [47:0] tt_s1;
	logic signed [55:0] a0t_s1, v0t_s1;
	// S2
	logic [23:0] t_s2;
	logic [47:0] t3p_s2 [2];
	logic signed [56:0] a0tt_s2 [2];
	logic signed [57:0] d2tt_s2 [2];
	logic signed [56:0] r1n_s2;
	logic signed [73:0] r0a_s2;
	// S3
	logic [23:0] t_s3;
	logic [71:0] t3_s3;
	logic signed [79:0] a0t2_s3;
	logic signed [80:0] d2t2_s3;
	logic signed [57:0] r1tp_hi_s3;
	logic [47:0] r1tp_lo_s3;
	logic signed [73:0] r0a_s3;
	// S4
	logic [23:0] t_s4;
	logic [71:0] t3_s4;
	logic [47:0] t4p_s4 [3];
	logic signed [80:0] r0n_s4, r1t_s4, d2t2_s4;
	// S5
	logic [23:0] t_s5;
	logic [71:0] t3_s5;
	logic [95:0] t4_s5;
	logic signed [mjq_pkg::N_W-1:0] n_s5 [3];
	// S6
	logic [71:0] t3_s6;
	logic [95:0] t4_s6;
	logic [47:0] t5p_s6 [4];
	logic [mjq_pkg::MAG_W-1:0] mag_s6 [3];
	logic [2:0] neg_s6;
	// S7
	logic [71:0] t3_s7;
	logic [95:0] t4_s7;
	logic [119:0] t5_s7;
	logic [mjq_pkg::MAG_W-1:0] mag_s7 [3];
	logic [2:0] neg_s7;

	logic signed [mjq_pkg::N_W-1:0] r0x, r1x, d2x;
	logic signed [mjq_pkg::C_W-1:0] c3, c4, c5;
	logic sat3, sat4, sat5;
	mjq_pkg::side_t side_fin;

	assign ib = in_chan.data;
	assign v_fin = vld_s[PIPE_N-1];
	assign take = !out_valid_q || out_chan.ready;
	assign adv = !v_fin || take;
	assign in_chan.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_N-2:0], in_chan.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0].p0 <= ib.start_position;
			side_s[0].v0 <= ib.start_velocity;
			side_s[0].a0 <= ib.start_accel;
			side_s[0].zero <= (ib.duration == '0);
			for (int i = 1; i < PIPE_N; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign r0x = mjq_pkg::N_W'(r0n_s4);
	assign r1x = mjq_pkg::N_W'(r1t_s4);
	assign d2x = mjq_pkg::N_W'(d2t2_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			// S1: differences, T^2, a0 T and v0 T
			dp_s1 <= 33'(ib.end_position) - 33'(ib.start_position);
			dv_s1 <= 33'(ib.end_velocity) - 33'(ib.start_velocity);
			d2_s1 <= 33'(ib.end_accel) - 33'(ib.start_accel);
			t_s1 <= ib.duration;
			tt_s1 <= 48'(ib.duration) * 48'(ib.duration);
			a0t_s1 <= 56'(ib.start_accel) * 56'($signed({1'b0, ib.duration}));
			v0t_s1 <= 56'(ib.start_velocity) * 56'($signed({1'b0, ib.duration}));

			// S2: partial products over 24-bit limbs of T^2
			t_s2 <= t_s1;
			for (int j = 0; j < 2; j++) begin
				t3p_s2[j] <= 48'(tt_s1[j*24 +: 24]) * 48'(t_s1);
				a0tt_s2[j] <= 57'(side_s[0].a0) * 57'($signed({1'b0, tt_s1[j*24 +: 24]}));
				d2tt_s2[j] <= 58'(d2_s1) * 58'($signed({1'b0, tt_s1[j*24 +: 24]}));
			end
			r1n_s2 <= (57'(dv_s1) <<< 16) - 57'(a0t_s1);
			r0a_s2 <= (74'(dp_s1) <<< 33) - (74'(v0t_s1) <<< 17);

			// S3
			t_s3 <= t_s2;
			t3_s3 <= (72'(t3p_s2[1]) << 24) + 72'(t3p_s2[0]);
			a0t2_s3 <= (80'(a0tt_s2[1]) <<< 24) + 80'(a0tt_s2[0]);
			d2t2_s3 <= (81'(d2tt_s2[1]) <<< 24) + 81'(d2tt_s2[0]);
			r1tp_hi_s3 <= 58'($signed(r1n_s2[56:24])) * 58'($signed({1'b0, t_s2}));
			r1tp_lo_s3 <= 48'(r1n_s2[23:0]) * 48'(t_s2);
			r0a_s3 <= r0a_s2;

			// S4
			t_s4 <= t_s3;
			t3_s4 <= t3_s3;
			for (int j = 0; j < 3; j++) begin
				t4p_s4[j] <= 48'(t3_s3[j*24 +: 24]) * 48'(t_s3);
			end
			r0n_s4 <= 81'(r0a_s3) - 81'(a0t2_s3);
			r1t_s4 <= (81'(r1tp_hi_s3) <<< 24) + 81'($signed({1'b0, r1tp_lo_s3}));
			d2t2_s4 <= d2t2_s3;

			// S5: numerators, small constants as shift-and-add
			t_s5 <= t_s4;
			t3_s5 <= t3_s4;
			t4_s5 <= (96'(t4p_s4[2]) << 48) + (96'(t4p_s4[1]) << 24) + 96'(t4p_s4[0]);
			n_s5[0] <= (r0x <<< 3) + (r0x <<< 1) - (r1x <<< 3) + d2x;
			n_s5[1] <= r0x - (r0x <<< 4) + (r1x <<< 4) - (r1x <<< 1) - (d2x <<< 1);
			n_s5[2] <= (r0x <<< 2) + (r0x <<< 1) - (r1x <<< 2) - (r1x <<< 1) + d2x;

			// S6
			t3_s6 <= t3_s5;
			t4_s6 <= t4_s5;
			for (int j = 0; j < 4; j++) begin
				t5p_s6[j] <= 48'(t4_s5[j*24 +: 24]) * 48'(t_s5);
			end
			for (int k = 0; k < 3; k++) begin
				neg_s6[k] <= n_s5[k][mjq_pkg::N_W-1];
				mag_s6[k] <= n_s5[k][mjq_pkg::N_W-1] ? mjq_pkg::MAG_W'(-n_s5[k])
					: mjq_pkg::MAG_W'(n_s5[k]);
			end

			// S7
			t3_s7 <= t3_s6;
			t4_s7 <= t4_s6;
			t5_s7 <= (120'(t5p_s6[3]) << 72) + (120'(t5p_s6[2]) << 48)
				+ (120'(t5p_s6[1]) << 24) + 120'(t5p_s6[0]);
			mag_s7 <= mag_s6;
			neg_s7 <= neg_s6;
		end
	end

	mjq_div #(
		.MAG_W(mjq_pkg::MAG_W),
		.DEN_W(mjq_pkg::D3_W),
		.SHIFT(mjq_pkg::SH3)
	) u_div3 (
		.clk(clk), .en(adv), .mag(mag_s7[0]), .den(t3_s7), .neg(neg_s7[0]),
		.coeff(c3), .sat(sat3)
	);

	mjq_div #(
		.MAG_W(mjq_pkg::MAG_W),
		.DEN_W(mjq_pkg::D4_W),
		.SHIFT(mjq_pkg::SH4)
	) u_div4 (
		.clk(clk), .en(adv), .mag(mag_s7[1]), .den(t4_s7), .neg(neg_s7[1]),
		.coeff(c4), .sat(sat4)
	);

	mjq_div #(
		.MAG_W(mjq_pkg::MAG_W),
		.DEN_W(mjq_pkg::D5_W),
		.SHIFT(mjq_pkg::SH5)
	) u_div5 (
		.clk(clk), .en(adv), .mag(mag_s7[2]), .den(t5_s7), .neg(neg_s7[2]),
		.coeff(c5), .sat(sat5)
	);

	assign side_fin = side_s[PIPE_N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= v_fin;
		end
	end

	// zero T: dividers ran on a zero divisor, so their output is discarded
	always_ff @(posedge clk) begin
		if (take && v_fin) begin
			out_q.coeff_0 <= mjq_pkg::C_W'(side_fin.p0) <<< 8;
			out_q.coeff_1 <= mjq_pkg::C_W'(side_fin.v0) <<< 8;
			out_q.coeff_2 <= mjq_pkg::C_W'(side_fin.a0) <<< 7;
			out_q.coeff_3 <= side_fin.zero ? '0 : c3;
			out_q.coeff_4 <= side_fin.zero ? '0 : c4;
			out_q.coeff_5 <= side_fin.zero ? '0 : c5;
			out_q.zero_duration <= side_fin.zero;
			out_q.saturated <= !side_fin.zero && (sat3 || sat4 || sat5);
		end
	end

	assign out_chan.valid = out_valid_q;
	assign out_chan.data = out_q;

	`MJQ_ASSERT_IMP(a_zero_dur_clear, clk, arst_n, out_chan.valid && out_chan.data.zero_duration, out_chan.data.coeff_3 == '0 && out_chan.data.coeff_4 == '0 && out_chan.data.coeff_5 == '0 && !out_chan.data.saturated)
	`MJQ_ASSERT_IMP(a_sat_at_bound, clk, arst_n, out_chan.valid && out_chan.data.saturated, out_chan.data.coeff_3 == mjq_pkg::C_MAX || out_chan.data.coeff_3 == mjq_pkg::C_MIN || out_chan.data.coeff_4 == mjq_pkg::C_MAX || out_chan.data.coeff_4 == mjq_pkg::C_MIN || out_chan.data.coeff_5 == mjq_pkg::C_MAX || out_chan.data.coeff_5 == mjq_pkg::C_MIN)
	`MJQ_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_chan.ready, v_fin && out_chan.valid && !out_chan.ready)
	`MJQ_ASSERT_NXT(a_fin_held, clk, arst_n, v_fin && !take, v_fin && out_chan.valid)

endmodule

@@ design/mjq_div.sv @@
module mjq_div #(
	parameter int MAG_W = mjq_pkg::MAG_W,
	parameter int DEN_W = mjq_pkg::D3_W,
	parameter int SHIFT = mjq_pkg::SH3
) (
	input  logic clk,
	input  logic en,
	input  logic [MAG_W-1:0] mag,
	input  logic [DEN_W-1:0] den,
	input  logic neg,
	output logic signed [mjq_pkg::C_W-1:0] coeff,
	output logic sat
);
	localparam int QW = mjq_pkg::Q_W;
	localparam int NUM_W = MAG_W + SHIFT + 1;
	localparam int E_W = DEN_W + 1;
	localparam int HI_W = NUM_W - QW;
	localparam int CMP_W = (HI_W > E_W) ? HI_W : E_W;
	localparam logic [QW-1:0] POS_LIM = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] NEG_LIM = {1'b1, {(QW-1){1'b0}}};

	// round half away: floor((|n| * 2^sh + D) / 2D)
	logic [NUM_W-1:0] num_sa;
	logic [E_W-1:0] div_sa;
	logic neg_sa;

	logic [E_W-1:0] rem_st [QW+1];
	logic [QW-1:0] lo_st [QW+1];
	logic [QW-1:0] q_st [QW+1];
	logic [E_W-1:0] div_st [QW+1];
	logic neg_st [QW+1];
	logic ovf_st [QW+1];

	logic [QW-1:0] lim, val;
	logic over;

	always_ff @(posedge clk) begin
		if (en) begin
			num_sa <= (NUM_W'(mag) << SHIFT) + NUM_W'(den);
			div_sa <= E_W'(den) << 1;
			neg_sa <= neg;
		end
	end

	// quotient would need more than QW bits: clamp regardless
	always_ff @(posedge clk) begin
		if (en) begin
			rem_st[0] <= E_W'(num_sa >> QW);
			lo_st[0] <= num_sa[QW-1:0];
			q_st[0] <= '0;
			div_st[0] <= div_sa;
			neg_st[0] <= neg_sa;
			ovf_st[0] <= CMP_W'(num_sa[NUM_W-1:QW]) >= CMP_W'(div_sa);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [E_W:0] trial;
		logic ge;

		assign trial = {rem_st[k], lo_st[k][QW-1]};
		assign ge = trial >= {1'b0, div_st[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[k+1] <= ge ? E_W'(trial - {1'b0, div_st[k]}) : E_W'(trial);
				lo_st[k+1] <= lo_st[k] << 1;
				q_st[k+1] <= {q_st[k][QW-2:0], ge};
				div_st[k+1] <= div_st[k];
				neg_st[k+1] <= neg_st[k];
				ovf_st[k+1] <= ovf_st[k];
			end
		end
	end

	assign lim = neg_st[QW] ? NEG_LIM : POS_LIM;
	assign over = ovf_st[QW] || (q_st[QW] > lim);
	assign val = over ? lim : q_st[QW];

	always_ff @(posedge clk) begin
		if (en) begin
			coeff <= neg_st[QW] ? -$signed(val) : $signed(val);
			sat <= over;
		end
	end

endmodule
